// File: rtl/core/owbm_pkg.sv
`default_nettype none

package owbm_pkg;

  // Input item codes.
  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_RESET      = 3'd1,
    CMD_WRITE_BIT  = 3'd2,
    CMD_WRITE_BYTE = 3'd3,
    CMD_READ_BIT   = 3'd4,
    CMD_READ_BYTE  = 3'd5
  } owbm_cmd_e;

  // Slot sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_HIGH = 3'd2,
    PH_WR_LOW   = 3'd3,
    PH_WR_HIGH  = 3'd4,
    PH_RD_LOW   = 3'd5,
    PH_RD_HIGH  = 3'd6
  } owbm_phase_e;

  localparam int unsigned UsW = 9;

  // Slot timing in microseconds.
  localparam logic [UsW-1:0] T_RST_LOW    = 9'd485;
  localparam logic [UsW-1:0] T_RST_HIGH   = 9'd480;
  localparam logic [UsW-1:0] T_RST_SAMPLE = 9'd410;
  localparam logic [UsW-1:0] T_W1_LOW     = 9'd10;
  localparam logic [UsW-1:0] T_W1_HIGH    = 9'd55;
  localparam logic [UsW-1:0] T_W0_LOW     = 9'd65;
  localparam logic [UsW-1:0] T_W0_HIGH    = 9'd5;
  localparam logic [UsW-1:0] T_RD_LOW     = 9'd3;
  localparam logic [UsW-1:0] T_RD_HIGH    = 9'd57;
  localparam logic [UsW-1:0] T_RD_SAMPLE  = 9'd47;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       line_level;
  } owbm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_byte;
    logic       rejected;
  } owbm_out_t;

  typedef struct packed {
    owbm_phase_e    phase;
    logic [UsW-1:0] remaining_us;
    logic [2:0]     bit_position;
    logic [7:0]     tx_shift;
    logic [7:0]     rx_shift;
    logic           presence_flag;
    logic           byte_mode;
  } owbm_state_t;

endpackage

`default_nettype wire

// File: rtl/core/owbm_step.sv
`default_nettype none

module owbm_step (
  input  owbm_pkg::owbm_state_t st_i,
  input  owbm_pkg::owbm_in_t    in_i,
  output owbm_pkg::owbm_state_t st_o,
  output owbm_pkg::owbm_out_t   res_o
);
  import owbm_pkg::*;

  logic [UsW-1:0] rem_dec;
  logic [2:0]     rx_pos;
  logic           is_tick;

  assign is_tick = (in_i.cmd == CMD_TICK);
  assign rem_dec = (st_i.remaining_us != '0) ? st_i.remaining_us - 1'b1 : st_i.remaining_us;
  assign rx_pos  = st_i.byte_mode ? st_i.bit_position : 3'd0;

  // Next state.
  always_comb begin
    st_o = st_i;
    if (st_i.phase == PH_IDLE) begin
      case (in_i.cmd)
        CMD_RESET: begin
          st_o.phase        = PH_RST_LOW;
          st_o.remaining_us = T_RST_LOW;
        end
        CMD_WRITE_BIT, CMD_WRITE_BYTE: begin
          st_o.tx_shift     = (in_i.cmd == CMD_WRITE_BIT) ? {7'd0, in_i.tx_byte[0]}
                                                          : in_i.tx_byte;
          st_o.bit_position = (in_i.cmd == CMD_WRITE_BIT) ? LAST_BIT : 3'd0;
          st_o.phase        = PH_WR_LOW;
          st_o.remaining_us = in_i.tx_byte[0] ? T_W1_LOW : T_W0_LOW;
        end
        CMD_READ_BIT, CMD_READ_BYTE: begin
          st_o.byte_mode    = (in_i.cmd == CMD_READ_BYTE);
          st_o.bit_position = (in_i.cmd == CMD_READ_BIT) ? LAST_BIT : 3'd0;
          st_o.rx_shift     = '0;
          st_o.phase        = PH_RD_LOW;
          st_o.remaining_us = T_RD_LOW;
        end
        default: ;
      endcase
    end else if (is_tick) begin
      st_o.remaining_us = rem_dec;
      if (st_i.phase == PH_RST_HIGH && rem_dec == T_RST_SAMPLE) begin
        st_o.presence_flag = ~in_i.line_level;
      end
      if (st_i.phase == PH_RD_HIGH && rem_dec == T_RD_SAMPLE && in_i.line_level) begin
        st_o.rx_shift = st_i.rx_shift | (8'd1 << rx_pos);
      end
      if (rem_dec == '0) begin
        case (st_i.phase)
          PH_RST_LOW: begin
            st_o.phase        = PH_RST_HIGH;
            st_o.remaining_us = T_RST_HIGH;
          end
          PH_WR_LOW: begin
            st_o.phase        = PH_WR_HIGH;
            st_o.remaining_us = st_i.tx_shift[0] ? T_W1_HIGH : T_W0_HIGH;
          end
          PH_RD_LOW: begin
            st_o.phase        = PH_RD_HIGH;
            st_o.remaining_us = T_RD_HIGH;
          end
          PH_WR_HIGH: begin
            st_o.tx_shift = {1'b0, st_i.tx_shift[7:1]};
            if (st_i.bit_position == LAST_BIT) begin
              st_o.phase = PH_IDLE;
            end else begin
              st_o.bit_position = st_i.bit_position + 3'd1;
              st_o.phase        = PH_WR_LOW;
              st_o.remaining_us = st_i.tx_shift[1] ? T_W1_LOW : T_W0_LOW;
            end
          end
          PH_RD_HIGH: begin
            if (st_i.bit_position == LAST_BIT) begin
              st_o.phase = PH_IDLE;
            end else begin
              st_o.bit_position = st_i.bit_position + 3'd1;
              st_o.phase        = PH_RD_LOW;
              st_o.remaining_us = T_RD_LOW;
            end
          end
          default: st_o.phase = PH_IDLE;
        endcase
      end
    end
  end

  // Result fields.
  always_comb begin
    res_o           = '0;
    res_o.drive_low = (st_o.phase == PH_RST_LOW) || (st_o.phase == PH_WR_LOW) ||
                      (st_o.phase == PH_RD_LOW);
    res_o.busy_res  = (st_o.phase != PH_IDLE);
    res_o.done_res  = is_tick && (st_i.phase != PH_IDLE) && (st_o.phase == PH_IDLE);
    res_o.presence  = st_o.presence_flag;
    if (res_o.done_res && st_i.phase == PH_RD_HIGH) begin
      res_o.rx_byte = st_o.rx_shift;
    end
    res_o.rejected  = (st_i.phase != PH_IDLE) && (in_i.cmd inside {[CMD_RESET:CMD_READ_BYTE]});
  end

endmodule

`default_nettype wire

// File: rtl/core/one_wire_bus_master_core.sv
`default_nettype none

// One-wire bus master core. Every input beat is either a one-microsecond tick,
// which carries the bus level sampled during the microsecond just gone, or a
// command (bus reset with presence detect, write bit, write byte, read bit,
// read byte; bytes go least significant bit first). Every accepted beat yields
// exactly one result beat that tells the bus driver whether to pull the line
// low for the coming microsecond, together with busy, done, presence, the
// received data and a rejected flag for a command that arrived while an
// operation was still running. Commands take no bus time; only ticks advance
// the slot timers. The block takes one beat per clock cycle unless stalled:
// the whole update of the slot sequencer is a single combinational step from
// the state registers to the result register, so a result appears in the
// cycle after its beat is accepted. The result register is the only buffer,
// so input stall is raised exactly while a result is held and output stalls.

module one_wire_bus_master_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  owbm_pkg::owbm_in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output owbm_pkg::owbm_out_t out_data_o
);
  import owbm_pkg::*;

  owbm_state_t state_q, state_d;
  owbm_out_t   res_d, res_q;
  logic        out_valid_q;
  logic        accept;

  // The result register may load whenever it is empty or being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  owbm_step u_step (
    .st_i  (state_q),
    .in_i  (in_data_i),
    .st_o  (state_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

// File: rtl/core/owbm_checker.sv
`default_nettype none

module owbm_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_stall_o,
  input owbm_pkg::owbm_in_t  in_data_i,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input owbm_pkg::owbm_out_t out_data_o
);

  // A stalled result beat stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // Every accepted input beat produces a result beat on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // The input side only stalls while a result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A finishing operation leaves the block idle and never coincides with a refusal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res && !out_data_o.rejected)
    else $error("done result is busy or rejected");

  // Received data only shows together with done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.rx_byte != 8'd0) |-> out_data_o.done_res)
    else $error("received data without done");

endmodule

bind one_wire_bus_master_core owbm_checker u_owbm_checker (.*);

`default_nettype wire

// File: sim/tb_one_wire_bus_master_core.sv
`timescale 1ns / 100ps

module tb_one_wire_bus_master_core;
  import owbm_pkg::*;

  // The package names only the six real commands. The two spare encodings
  // are ignored by the block, but they fit in the field and are driven too.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  owbm_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  owbm_out_t out_data_o;

  one_wire_bus_master_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Our own copy of the slot sequencer. It advances once for every input
  // beat that the block accepts.
  owbm_phase_e    bus_phase;
  logic [UsW-1:0] us_left;
  logic [2:0]     slot_bit;
  logic [7:0]     tx_bits;
  logic [7:0]     rx_bits;
  logic           presence_seen;
  logic           whole_byte_read;

  // Results that the block still owes us, oldest first.
  owbm_out_t bus_results_due[$];
  owbm_out_t next_result;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int beats_sent;
  int ops_finished;
  int cmds_refused;
  int resets_with_device;

  function automatic void start_write_slot();
    bus_phase = PH_WR_LOW;
    us_left   = tx_bits[0] ? T_W1_LOW : T_W0_LOW;
  endfunction

  function automatic void start_read_slot();
    bus_phase = PH_RD_LOW;
    us_left   = T_RD_LOW;
  endfunction

  // One microsecond passes. Returns 1 when the whole operation is over.
  function automatic logic advance_one_us(input logic level);
    if (us_left != '0) begin
      us_left = us_left - 1'b1;
    end
    // A device that answers the reset holds the line low at the sample point.
    if (bus_phase == PH_RST_HIGH && us_left == T_RST_SAMPLE) begin
      presence_seen = ~level;
    end
    // A single-bit read always lands in bit 0.
    if (bus_phase == PH_RD_HIGH && us_left == T_RD_SAMPLE && level) begin
      rx_bits[whole_byte_read ? slot_bit : 3'd0] = 1'b1;
    end
    if (us_left != '0) begin
      return 1'b0;
    end
    case (bus_phase)
      PH_RST_LOW: begin
        bus_phase = PH_RST_HIGH;
        us_left   = T_RST_HIGH;
        return 1'b0;
      end
      PH_WR_LOW: begin
        bus_phase = PH_WR_HIGH;
        us_left   = tx_bits[0] ? T_W1_HIGH : T_W0_HIGH;
        return 1'b0;
      end
      PH_RD_LOW: begin
        bus_phase = PH_RD_HIGH;
        us_left   = T_RD_HIGH;
        return 1'b0;
      end
      PH_WR_HIGH: begin
        tx_bits = tx_bits >> 1;
        if (slot_bit != LAST_BIT) begin
          slot_bit = slot_bit + 1'b1;
          start_write_slot();
          return 1'b0;
        end
      end
      PH_RD_HIGH: begin
        if (slot_bit != LAST_BIT) begin
          slot_bit = slot_bit + 1'b1;
          start_read_slot();
          return 1'b0;
        end
      end
      default: ;
    endcase
    bus_phase = PH_IDLE;
    return 1'b1;
  endfunction

  // Applies one beat to the sequencer copy and returns the result it causes.
  function automatic owbm_out_t predict_bus_result(input owbm_in_t beat);
    owbm_out_t   res;
    owbm_phase_e was;
    res = '0;
    case (beat.cmd)
      CMD_TICK: begin
        // A tick while idle carries a level that nobody looks at.
        if (bus_phase != PH_IDLE) begin
          was = bus_phase;
          if (advance_one_us(beat.line_level)) begin
            res.done_res = 1'b1;
            if (was == PH_RD_HIGH) begin
              res.rx_byte = rx_bits;
            end
          end
        end
      end
      CMD_RESET, CMD_WRITE_BIT, CMD_WRITE_BYTE, CMD_READ_BIT, CMD_READ_BYTE: begin
        if (bus_phase != PH_IDLE) begin
          res.rejected = 1'b1;
        end else if (beat.cmd == CMD_RESET) begin
          bus_phase = PH_RST_LOW;
          us_left   = T_RST_LOW;
        end else if (beat.cmd == CMD_WRITE_BIT || beat.cmd == CMD_WRITE_BYTE) begin
          // A lone bit runs as the last slot of a byte.
          tx_bits  = (beat.cmd == CMD_WRITE_BIT) ? {7'd0, beat.tx_byte[0]} : beat.tx_byte;
          slot_bit = (beat.cmd == CMD_WRITE_BIT) ? LAST_BIT : 3'd0;
          start_write_slot();
        end else begin
          whole_byte_read = (beat.cmd == CMD_READ_BYTE);
          slot_bit        = (beat.cmd == CMD_READ_BIT) ? LAST_BIT : 3'd0;
          rx_bits         = '0;
          start_read_slot();
        end
      end
      default: ;  // spare encodings change nothing
    endcase
    res.drive_low = (bus_phase == PH_RST_LOW || bus_phase == PH_WR_LOW ||
                     bus_phase == PH_RD_LOW);
    res.busy_res  = (bus_phase != PH_IDLE);
    res.presence  = presence_seen;
    return res;
  endfunction

  // Presents one beat from a falling edge, with a random gap ahead of it,
  // and holds it steady until the rising edge that accepts it.
  task automatic send_beat(input logic [2:0] cmd, input logic [7:0] txb, input logic level);
    owbm_in_t  beat;
    owbm_out_t want;
    beat.cmd        = cmd;
    beat.tx_byte    = txb;
    beat.line_level = level;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    want = predict_bus_result(beat);
    bus_results_due.push_back(want);
    beats_sent++;
    ops_finished += want.done_res;
    cmds_refused += want.rejected;
    @(negedge clk_i);
  endtask

  task automatic send_random_cmd();
    send_beat(3'($urandom_range(1, 7)), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Ticks until the running operation is over. high_pct sets how often the
  // line reads back high; noise_pct mixes in commands while busy.
  task automatic run_ticks(input int high_pct, input int noise_pct);
    while (bus_phase != PH_IDLE) begin
      if ($urandom_range(99) < noise_pct) begin
        send_random_cmd();
      end else begin
        send_beat(CMD_TICK, 8'($urandom_range(255)), $urandom_range(99) < high_pct);
      end
    end
  endtask

  task automatic run_op(input logic [2:0] cmd, input logic [7:0] txb, input int high_pct);
    send_beat(cmd, txb, 1'($urandom_range(1)));
    run_ticks(high_pct, 0);
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (bus_results_due.size() != 0);
  endtask

  task automatic check_field(input string field_name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%02h, actual 0x%02h",
               $time, field_name, want, got);
      mismatches++;
    end
  endtask

  // Every result beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bus_results_due.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %p", $time, out_data_o);
        mismatches++;
      end else begin
        next_result = bus_results_due.pop_front();
        check_field("drive_low", 8'(next_result.drive_low), 8'(out_data_o.drive_low));
        check_field("busy_res",  8'(next_result.busy_res),  8'(out_data_o.busy_res));
        check_field("done_res",  8'(next_result.done_res),  8'(out_data_o.done_res));
        check_field("presence",  8'(next_result.presence),  8'(out_data_o.presence));
        check_field("rx_byte",   next_result.rx_byte,       out_data_o.rx_byte);
        check_field("rejected",  8'(next_result.rejected),  8'(out_data_o.rejected));
      end
    end
  end

  // The result side stalls at random from one falling edge to the next.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Ticks while idle and the spare encodings must leave the block untouched.
  task automatic test_idle_items();
    send_beat(CMD_TICK, 8'h00, 1'b0);
    send_beat(CMD_TICK, 8'hFF, 1'b1);
    send_beat(CMD_SPARE_A, 8'hFF, 1'b1);
    send_beat(CMD_SPARE_B, 8'h00, 1'b0);
  endtask

  // Bus reset with a device pulling the line low at the sample point.
  task automatic test_bus_reset();
    run_op(CMD_RESET, 8'h00, 0);
    resets_with_device++;
  endtask

  // Only bit 0 of the byte may matter for a single-bit write.
  task automatic test_write_bit();
    run_op(CMD_WRITE_BIT, 8'hFE, 50);
  endtask

  // Mixed ones and zeros exercise both slot lengths and the shift order.
  task automatic test_write_byte();
    run_op(CMD_WRITE_BYTE, 8'hA5, 50);
  endtask

  // Every encoding arrives in the middle of a byte read; the real commands
  // must be refused and the spare ones ignored. Then a single-bit read right
  // after done, and a tick once idle again.
  task automatic test_busy_commands();
    send_beat(CMD_READ_BYTE, 8'h00, 1'b1);
    send_beat(CMD_TICK, 8'h00, 1'b1);
    for (int c = CMD_RESET; c <= CMD_SPARE_B; c++) begin
      send_beat(c[2:0], 8'($urandom_range(255)), 1'($urandom_range(1)));
      send_beat(CMD_TICK, 8'h00, 1'($urandom_range(1)));
    end
    run_ticks(50, 3);
    run_op(CMD_READ_BIT, 8'h00, 50);
    send_beat(CMD_TICK, 8'h00, 1'b0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_stall_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    beats_sent     = 0;
    ops_finished   = 0;
    cmds_refused   = 0;
    resets_with_device = 0;
    bus_phase       = PH_IDLE;
    us_left         = '0;
    slot_bit        = '0;
    tx_bits         = '0;
    rx_bits         = '0;
    presence_seen   = 1'b0;
    whole_byte_read = 1'b0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Phase one: the sender idles now and then, the receiver often.
    send_idle_pct  = 24;
    recv_stall_pct = 49;
    test_idle_items();
    test_bus_reset();
    wait_all_results();

    // Phase two: the roles swap.
    send_idle_pct  = 49;
    recv_stall_pct = 24;
    test_write_bit();
    test_write_byte();

    // Phase three: full rate on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_busy_commands();

    wait_all_results();
    repeat (8) @(negedge clk_i);

    $display("Covered %0d beats: %0d finished operations, %0d refused commands,",
             beats_sent, ops_finished, cmds_refused);
    $display("a bus reset with a device present, bit and byte writes and reads, idle noise.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Safety net in case the block stops handshaking.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
